### sv/acr_pkg.sv
package acr_pkg;

  localparam int RADIUS_BITS_DEF   = 10;
  localparam int FRACTION_BITS_DEF = 8;
  localparam int ROW_W    = 11;
  localparam int COORD_W  = 16;
  localparam int CMP_W    = 16;
  localparam int COLOR_W  = 32;
  localparam int ALPHA_W  = 8;
  localparam int ALPHA_LSB = 24;
  localparam logic [COLOR_W-1:0] RGB_MASK = 32'h00FF_FFFF;
  localparam int NUM_SLOTS = 10;
  localparam int SLOT_W    = 4;

  typedef enum logic [1:0] {
    CFG_CENTER_X = 2'd0,
    CFG_CENTER_Y = 2'd1,
    CFG_RADIUS   = 2'd2,
    CFG_COLOR    = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_MUL, S_SUB, S_SQRT, S_FADE, S_UPD, S_EMIT
  } eng_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] x_first;
    logic [COORD_W-1:0] x_final;
    logic [COORD_W-1:0] y;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               done;
  } res_t;

  typedef struct packed {
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic [COLOR_W-1:0] argb;
  } geom_t;

endpackage

### sv/acr_fifo.sv
module acr_fifo import acr_pkg::*; #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW:0] wp_r, wp_nxt, rp_r, rp_nxt;

  assign empty = (wp_r == rp_r);
  assign full  = (wp_r[AW-1:0] == rp_r[AW-1:0]) && (wp_r[AW] != rp_r[AW]);
  assign rdata = mem[rp_r[AW-1:0]];

  always_comb begin
    wp_nxt = wp_r;
    rp_nxt = rp_r;
    if (push && !full) wp_nxt = wp_r + 1'b1;
    if (pop && !empty) rp_nxt = rp_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) mem[wp_r[AW-1:0]] <= wdata;
  end

endmodule

### sv/acr_engine.sv
module acr_engine import acr_pkg::*; #(
  parameter int RADIUS_BITS   = RADIUS_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  logic                   q_start,
  output logic                   q_pop,
  input  geom_t                  geom,
  input  logic [RADIUS_BITS-1:0] rad,
  input  logic                   o_full,
  output logic                   o_push,
  output res_t                   o_data
);

  localparam int RB   = RADIUS_BITS;
  localparam int FB   = FRACTION_BITS;
  localparam int RW   = RB + FB;
  localparam int SW   = 2 * RB + 2 * FB;
  localparam int VW   = 2 * RB;
  localparam int IIW  = 2 * ROW_W;
  localparam int PW   = (VW > IIW) ? VW : IIW;
  localparam int FW   = ALPHA_W + FB;
  localparam int CNTW = $clog2(RW);

  eng_state_t state_r, state_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt, rim_r, rim_nxt;
  logic [FW-1:0]     pfade_r, pfade_nxt, fade_r, fade_nxt;
  logic              fill_r, fill_nxt, active_r, active_nxt;
  logic [VW-1:0]     rr_r, rr_nxt;
  logic [IIW-1:0]    ii_r, ii_nxt;
  logic [SW-1:0]     op_r, op_nxt;
  logic [RW-1:0]     root_r, root_nxt;
  logic [RW+1:0]     rem_r, rem_nxt;
  logic [CNTW-1:0]   cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] k_r, k_nxt;
  logic [NUM_SLOTS-1:0] en_r, en_nxt;
  logic [ROW_W-1:0]  hw_r, hw_nxt, ei_r, ei_nxt;
  logic [COLOR_W-1:0] ecol_r, ecol_nxt;
  logic              edone_r, edone_nxt;

  logic [PW-1:0]     rr_e, ii_e;
  logic [VW-1:0]     v;
  logic [RW+3:0]     t, trial;
  logic [ROW_W-1:0]  i1, j;
  logic [RB-1:0]     s;
  logic [CMP_W-1:0]  rad_c, row_c, i1_c;
  logic              dn;

  assign rad_c = CMP_W'(rad);
  assign row_c = CMP_W'(row_r);

  always_comb begin
    state_nxt = state_r;
    row_nxt = row_r;   rim_nxt = rim_r;   pfade_nxt = pfade_r;
    fade_nxt = fade_r; fill_nxt = fill_r; active_nxt = active_r;
    rr_nxt = rr_r;     ii_nxt = ii_r;     op_nxt = op_r;
    root_nxt = root_r; rem_nxt = rem_r;   cnt_nxt = cnt_r;
    k_nxt = k_r;       en_nxt = en_r;     hw_nxt = hw_r;
    ei_nxt = ei_r;     ecol_nxt = ecol_r; edone_nxt = edone_r;
    q_pop = 1'b0;
    o_push = 1'b0;
    rr_e = PW'(rr_r);
    ii_e = PW'(ii_r);
    v = (rr_e > ii_e) ? VW'(rr_e - ii_e) : '0;
    t = {rem_r, op_r[SW-1:SW-2]};
    trial = {2'b00, root_r, 2'b01};
    i1 = row_r + 1'b1;
    i1_c = CMP_W'(i1);
    j = rim_r;
    s = root_r[RW-1:FB];
    dn = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          if (q_start) begin
            row_nxt = '0;
            rim_nxt = ROW_W'(rad_c + CMP_W'(1));
            pfade_nxt = '0;
            fill_nxt = 1'b0;
            active_nxt = 1'b1;
          end
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!active_r) begin
          state_nxt = S_IDLE;
        end else if (fill_r && !(row_c < rad_c)) begin
          active_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        rr_nxt = {{RB{1'b0}}, rad} * {{RB{1'b0}}, rad};
        ii_nxt = {{ROW_W{1'b0}}, row_r} * {{ROW_W{1'b0}}, row_r};
        state_nxt = S_SUB;
      end
      S_SUB: begin
        op_nxt = {v, {(2 * FB){1'b0}}};
        root_nxt = '0;
        rem_nxt = '0;
        cnt_nxt = '0;
        state_nxt = S_SQRT;
      end
      S_SQRT: begin
        // one root bit per cycle, restoring
        if (t >= trial) begin
          rem_nxt = (RW+2)'(t - trial);
          root_nxt = {root_r[RW-2:0], 1'b1};
        end else begin
          rem_nxt = (RW+2)'(t);
          root_nxt = {root_r[RW-2:0], 1'b0};
        end
        op_nxt = {op_r[SW-3:0], 2'b00};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNTW'(RW - 1)) state_nxt = S_FADE;
      end
      S_FADE: begin
        if (rem_r == '0) begin
          fade_nxt = {geom.argb[COLOR_W-1:ALPHA_LSB], {FB{1'b0}}};
        end else begin
          fade_nxt = {{FB{1'b0}}, geom.argb[COLOR_W-1:ALPHA_LSB]} *
                     {{ALPHA_W{1'b0}}, root_r[FB-1:0]};
        end
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!fill_r) begin
          if (fade_r > pfade_r && j != '0) j = j - 1'b1;
          pfade_nxt = fade_r;
          rim_nxt = j;
          hw_nxt = j;
          ecol_nxt = {fade_r[FW-1:FB], geom.argb[ALPHA_LSB-1:0]};
          en_nxt[0] = 1'b1;
          en_nxt[1] = 1'b1;
          en_nxt[2] = (row_r != '0);
          en_nxt[3] = (row_r != '0);
          en_nxt[4] = (row_r != j);
          en_nxt[5] = (row_r != j);
          en_nxt[6] = (row_r != j) && (row_r != '0);
          en_nxt[7] = (row_r != j) && (row_r != '0);
          en_nxt[8] = (j != '0);
          en_nxt[9] = (j != '0) && (row_r != '0);
          if (!(i1 < j)) begin
            fill_nxt = 1'b1;
            dn = !(i1_c < rad_c);
          end
        end else begin
          hw_nxt = ROW_W'(CMP_W'(s) + CMP_W'(rem_r != '0));
          en_nxt = '0;
          en_nxt[8] = 1'b1;
          en_nxt[9] = 1'b1;
          dn = !(i1_c < rad_c);
        end
        ei_nxt = row_r;
        row_nxt = i1;
        edone_nxt = dn;
        if (dn) active_nxt = 1'b0;
        k_nxt = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!(en_r[k_r] && o_full)) begin
          o_push = en_r[k_r];
          if (k_r == SLOT_W'(NUM_SLOTS - 1)) state_nxt = S_IDLE;
          else k_nxt = k_r + 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  logic [COORD_W-1:0] iw, jw, ax, ay;
  logic later;

  always_comb begin
    iw = COORD_W'(ei_r);
    jw = COORD_W'(hw_r);
    ax = geom.cx;
    ay = geom.cy;
    o_data.color = ecol_r;
    case (k_r)
      4'd0: begin ax = geom.cx + iw; ay = geom.cy + jw; end
      4'd1: begin ax = geom.cx + iw; ay = geom.cy - jw; end
      4'd2: begin ax = geom.cx - iw; ay = geom.cy + jw; end
      4'd3: begin ax = geom.cx - iw; ay = geom.cy - jw; end
      4'd4: begin ax = geom.cx + jw; ay = geom.cy + iw; end
      4'd5: begin ax = geom.cx - jw; ay = geom.cy + iw; end
      4'd6: begin ax = geom.cx + jw; ay = geom.cy - iw; end
      4'd7: begin ax = geom.cx - jw; ay = geom.cy - iw; end
      4'd8: begin ay = geom.cy + iw; o_data.color = geom.argb; end
      default: begin ay = geom.cy - iw; o_data.color = geom.argb; end
    endcase
    if (k_r >= SLOT_W'(8)) begin
      o_data.x_first = geom.cx - jw + COORD_W'(1);
      o_data.x_final = geom.cx + jw - COORD_W'(1);
    end else begin
      o_data.x_first = ax;
      o_data.x_final = ax;
    end
    o_data.y = ay;
    later = 1'b0;
    for (int m = 0; m < NUM_SLOTS; m++) begin
      if (SLOT_W'(m) > k_r && en_r[m]) later = 1'b1;
    end
    o_data.last = !later;
    o_data.done = edone_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      row_r    <= '0;
      rim_r    <= '0;
      pfade_r  <= '0;
      fill_r   <= 1'b0;
      active_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      rim_r    <= rim_nxt;
      pfade_r  <= pfade_nxt;
      fill_r   <= fill_nxt;
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fade_r  <= fade_nxt;
    rr_r    <= rr_nxt;
    ii_r    <= ii_nxt;
    op_r    <= op_nxt;
    root_r  <= root_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    k_r     <= k_nxt;
    en_r    <= en_nxt;
    hw_r    <= hw_nxt;
    ei_r    <= ei_nxt;
    ecol_r  <= ecol_nxt;
    edone_r <= edone_nxt;
  end

endmodule

### sv/antialiased_filled_circle_raster.sv
// Antialiased filled circle rasterizer, one row per input item.
// Config: write cfg_wdata to register cfg_index (0 center_x, 1 center_y,
// 2 radius, 3 argb_color) with cfg_wr_en; only while the block is idle.
// Input: push an item (in_start_req) when in_full is low. start_req=1
// restarts at row 0, start_req=0 advances one row; nothing comes out
// for an advance while no circle is active.
// Output: while out_empty is low the oldest run is on the out_ ports; pop
// takes it. last_of_row marks the final run of an item, circle_done marks
// every run of the item that finished the circle.
// Per row: control states and a bit-serial square root of
// RADIUS_BITS+FRACTION_BITS bits, then ten emit slots; an enabled slot
// waits while the output queue is full. The square root unit
// and the emit sequencer are the limit. A two-entry input queue lets
// items be taken while the engine works.
// Reset (synchronous, rst_n low) empties both queues, clears the circle
// state and the config registers. A stalled receiver backs up the output queue;
// the engine then holds in place and the input queue fills and raises full.
module antialiased_filled_circle_raster import acr_pkg::*; #(
  parameter int RADIUS_BITS   = RADIUS_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic                  in_start_req,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic signed [15:0]    out_span_x_first,
  output logic signed [15:0]    out_span_x_final,
  output logic signed [15:0]    out_span_y,
  output logic [31:0]           out_pixel_color,
  output logic                  out_last_of_row,
  output logic                  out_circle_done,
  input  logic                  cfg_wr_en,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_wdata
);

  geom_t geom_r, geom_nxt;
  logic [RADIUS_BITS-1:0] radius_r, radius_nxt;

  always_comb begin
    geom_nxt = geom_r;
    radius_nxt = radius_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CENTER_X: geom_nxt.cx = cfg_wdata[COORD_W-1:0];
        CFG_CENTER_Y: geom_nxt.cy = cfg_wdata[COORD_W-1:0];
        CFG_RADIUS:   radius_nxt = RADIUS_BITS'(cfg_wdata[9:0]);
        CFG_COLOR:    geom_nxt.argb = cfg_wdata;
        default:      geom_nxt = geom_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geom_r   <= '0;
      radius_r <= '0;
    end else begin
      geom_r   <= geom_nxt;
      radius_r <= radius_nxt;
    end
  end

  logic q_empty, q_pop, q_start;
  logic o_full, o_push;
  res_t o_wdata, o_rdata;

  acr_fifo #(.WIDTH(1), .DEPTH(2)) u_in_q (
    .clk(clk), .rst_n(rst_n),
    .push(in_push), .wdata(in_start_req), .full(in_full),
    .pop(q_pop), .rdata(q_start), .empty(q_empty)
  );

  acr_engine #(.RADIUS_BITS(RADIUS_BITS), .FRACTION_BITS(FRACTION_BITS)) u_eng (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .q_start(q_start), .q_pop(q_pop),
    .geom(geom_r), .rad(radius_r),
    .o_full(o_full), .o_push(o_push), .o_data(o_wdata)
  );

  acr_fifo #(.WIDTH($bits(res_t)), .DEPTH(4)) u_out_q (
    .clk(clk), .rst_n(rst_n),
    .push(o_push), .wdata(o_wdata), .full(o_full),
    .pop(out_pop), .rdata(o_rdata), .empty(out_empty)
  );

  assign out_span_x_first = o_rdata.x_first;
  assign out_span_x_final = o_rdata.x_final;
  assign out_span_y       = o_rdata.y;
  assign out_pixel_color  = o_rdata.color;
  assign out_last_of_row  = o_rdata.last;
  assign out_circle_done  = o_rdata.done;

endmodule

### sv/acr_checker.sv
module acr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [15:0] out_span_y,
  input logic [31:0] out_pixel_color
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  a_rst_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full after reset");

  a_hold_y: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_span_y))
    else $error("row changed while stalled");

  a_hold_col: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> $stable(out_pixel_color))
    else $error("color changed while stalled");

endmodule

bind antialiased_filled_circle_raster acr_checker u_acr_checker (
  .clk(clk), .rst_n(rst_n), .in_full(in_full), .out_empty(out_empty),
  .out_pop(out_pop), .out_span_y(out_span_y), .out_pixel_color(out_pixel_color)
);

### tb/sv/antialiased_filled_circle_raster_tb.sv
`timescale 1ns / 100ps

module antialiased_filled_circle_raster_tb;
  import acr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 150;

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0;
  logic in_start_req = 0;
  logic out_pop = 0;
  logic cfg_wr_en = 0;
  cfg_idx_t cfg_index = CFG_CENTER_X;
  logic [31:0] cfg_wdata = '0;
  logic in_full, out_empty, out_last_of_row, out_circle_done;
  logic signed [15:0] out_span_x_first, out_span_x_final, out_span_y;
  logic [31:0] out_pixel_color;

  antialiased_filled_circle_raster DUT (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_start_req(in_start_req),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_span_x_first(out_span_x_first), .out_span_x_final(out_span_x_final),
    .out_span_y(out_span_y), .out_pixel_color(out_pixel_color),
    .out_last_of_row(out_last_of_row), .out_circle_done(out_circle_done),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // circle model state
  logic [15:0] center_x_q, center_y_q;
  logic [9:0]  radius_q;
  logic [31:0] argb_q;
  logic [10:0] row_q, rim_q;
  int unsigned prev_fade_q;
  bit          fill_q, active_q;

  res_t expected_runs[$];
  res_t row_runs[$];
  int   fails = 0;
  int   items_sent = 0;
  int   cycles = 0;

  initial forever #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint unsigned height_sq(logic [10:0] i);
    longint unsigned rr, ii;
    rr = longint'(radius_q) * radius_q;
    ii = longint'(i) * i;
    return (rr > ii) ? rr - ii : 0;
  endfunction

  function automatic void add_run(logic [15:0] x0, logic [15:0] x1, logic [15:0] y,
                                  logic [31:0] col);
    res_t r;
    if (row_runs.size() >= NUM_SLOTS) return;
    r.x_first = x0;
    r.x_final = x1;
    r.y = y;
    r.color = col;
    r.last = 1'b0;
    r.done = 1'b0;
    row_runs.push_back(r);
  endfunction

  // expected runs of one accepted row item
  function automatic void predict_row(bit start);
    logic [10:0] i, j;
    longint unsigned v, h, s, frac;
    int unsigned fade, maxa, len;
    logic [31:0] col;
    bit done;
    done = 0;
    row_runs.delete();
    maxa = argb_q[31:24];
    if (start) begin
      row_q = 0;
      rim_q = 11'(radius_q) + 11'd1;
      prev_fade_q = 0;
      fill_q = 0;
      active_q = 1;
    end
    if (!active_q) return;
    i = row_q;
    j = rim_q;
    if (!fill_q) begin
      v = height_sq(i);
      h = sqrt_floor(v << (2 * FRACTION_BITS_DEF));
      s = h >> FRACTION_BITS_DEF;
      frac = h & ((64'd1 << FRACTION_BITS_DEF) - 1);
      fade = (s * s == v) ? (maxa << FRACTION_BITS_DEF) : maxa * int'(frac);
      if (fade > prev_fade_q && j > 0) j = j - 11'd1;
      prev_fade_q = fade;
      col = (argb_q & RGB_MASK) | ((fade >> FRACTION_BITS_DEF) << ALPHA_LSB);
      add_run(center_x_q + 16'(i), center_x_q + 16'(i), center_y_q + 16'(j), col);
      add_run(center_x_q + 16'(i), center_x_q + 16'(i), center_y_q - 16'(j), col);
      if (i != 0) begin
        add_run(center_x_q - 16'(i), center_x_q - 16'(i), center_y_q + 16'(j), col);
        add_run(center_x_q - 16'(i), center_x_q - 16'(i), center_y_q - 16'(j), col);
      end
      if (i != j) begin
        add_run(center_x_q + 16'(j), center_x_q + 16'(j), center_y_q + 16'(i), col);
        add_run(center_x_q - 16'(j), center_x_q - 16'(j), center_y_q + 16'(i), col);
        if (i != 0) begin
          add_run(center_x_q + 16'(j), center_x_q + 16'(j), center_y_q - 16'(i), col);
          add_run(center_x_q - 16'(j), center_x_q - 16'(j), center_y_q - 16'(i), col);
        end
      end
      if (j >= 1) begin
        add_run(center_x_q - 16'(j) + 16'd1, center_x_q + 16'(j) - 16'd1,
                center_y_q + 16'(i), argb_q);
        if (i != 0)
          add_run(center_x_q - 16'(j) + 16'd1, center_x_q + 16'(j) - 16'd1,
                  center_y_q - 16'(i), argb_q);
      end
      i = i + 11'd1;
      if (!(i < j)) begin
        fill_q = 1;
        if (!(i < 11'(radius_q))) done = 1;
      end
    end else begin
      if (!(i < 11'(radius_q))) begin
        active_q = 0;
        return;
      end
      v = height_sq(i);
      s = sqrt_floor(v);
      len = int'(s) + ((s * s != v) ? 1 : 0);
      add_run(center_x_q - 16'(len) + 16'd1, center_x_q + 16'(len) - 16'd1,
              center_y_q + 16'(i), argb_q);
      add_run(center_x_q - 16'(len) + 16'd1, center_x_q + 16'(len) - 16'd1,
              center_y_q - 16'(i), argb_q);
      i = i + 11'd1;
      if (!(i < 11'(radius_q))) done = 1;
    end
    row_q = i;
    rim_q = j;
    if (done) active_q = 0;
    if (row_runs.size() > 0) row_runs[row_runs.size() - 1].last = 1'b1;
    foreach (row_runs[k]) begin
      row_runs[k].done = done;
      expected_runs.push_back(row_runs[k]);
    end
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
    fails++;
  endtask

  // receiver with random stalls
  int pop_gap = 0;
  always @(posedge clk) begin
    res_t e;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_runs.size() == 0) begin
        report("unexpected item", 32'(out_span_y), 32'd0);
      end else begin
        e = expected_runs.pop_front();
        if (out_span_x_first !== e.x_first)
          report("x_first", 32'(out_span_x_first), 32'(e.x_first));
        if (out_span_x_final !== e.x_final)
          report("x_final", 32'(out_span_x_final), 32'(e.x_final));
        if (out_span_y !== e.y) report("y", 32'(out_span_y), 32'(e.y));
        if (out_pixel_color !== e.color) report("color", out_pixel_color, e.color);
        if (out_last_of_row !== e.last)
          report("last", 32'(out_last_of_row), 32'(e.last));
        if (out_circle_done !== e.done)
          report("done", 32'(out_circle_done), 32'(e.done));
      end
    end
    if (pop_gap > 0) begin
      pop_gap <= pop_gap - 1;
      out_pop <= 0;
    end else begin
      pop_gap <= gap_len();
      out_pop <= 1;
    end
  end

  task automatic send_row(bit start);
    int g;
    in_push <= 1;
    in_start_req <= start;
    do @(posedge clk); while (in_full);
    predict_row(start);
    items_sent++;
    g = gap_len();
    if (g > 0) begin
      in_push <= 0;
      in_start_req <= 1'($urandom_range(0, 1));
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_push <= 0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic set_cfg(logic [15:0] cx, logic [15:0] cy, logic [9:0] r, logic [31:0] c);
    cfg_wr_en <= 1;
    cfg_index <= CFG_CENTER_X;
    cfg_wdata <= {16'h0, cx};
    @(posedge clk);
    center_x_q = cx;
    cfg_index <= CFG_CENTER_Y;
    cfg_wdata <= {16'h0, cy};
    @(posedge clk);
    center_y_q = cy;
    cfg_index <= CFG_RADIUS;
    cfg_wdata <= {22'h0, r};
    @(posedge clk);
    radius_q = r;
    cfg_index <= CFG_COLOR;
    cfg_wdata <= c;
    @(posedge clk);
    argb_q = c;
    cfg_wr_en <= 0;
  endtask

  task automatic run_rows(bit start, int n);
    if (start) send_row(1);
    repeat (n) send_row(0);
  endtask

  task automatic test_directed();
    set_cfg(16'h0000, 16'h0000, 10'd0, 32'hFF12_3456);
    run_rows(1, 1);
    settle();
    set_cfg(16'h7FFF, 16'h8000, 10'd1, 32'h80AB_CDEF);
    run_rows(1, 3);
    settle();
    set_cfg(16'hFFFB, 16'h0003, 10'd2, 32'h00FF_FFFF);
    run_rows(1, 3);
    settle();
    set_cfg(16'h0064, 16'hFF9C, 10'd5, 32'hFFFF_FFFF);
    run_rows(1, 2);
    settle();
    set_cfg(16'h0064, 16'hFF9C, 10'd2, 32'hFFFF_FFFF);
    run_rows(0, 3);
    settle();
    set_cfg(16'h0000, 16'h0000, 10'd1023, 32'h7F00_0000);
    run_rows(1, 2);
    settle();
    set_cfg(16'h1234, 16'hEDCB, 10'd3, 32'hC0FF_EE00);
    run_rows(1, 2);
    run_rows(1, 1);
    settle();
  endtask

  task automatic test_random();
    logic [9:0] r;
    int n;
    while (items_sent < 330) begin
      case ($urandom_range(0, 9))
        0: r = 10'($urandom_range(0, 1023));
        1: r = 10'($urandom_range(100, 1023));
        default: r = 10'($urandom_range(0, 20));
      endcase
      if ($urandom_range(0, 5) == 0 && active_q)
        set_cfg(center_x_q, center_y_q, r, argb_q);
      else
        set_cfg(16'($urandom), 16'($urandom), r, $urandom);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_row(1'($urandom_range(0, 1)));
      end else begin
        n = (r > 24) ? $urandom_range(0, 6) : $urandom_range(0, 2 * r + 3);
        run_rows($urandom_range(0, 7) != 0 || !active_q, n);
      end
      settle();
    end
  endtask

  initial begin
    center_x_q = 0; center_y_q = 0; radius_q = 0; argb_q = 0;
    row_q = 0; rim_q = 0; prev_fade_q = 0; fill_q = 0; active_q = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random();
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fails == 0 && expected_runs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
